@@ sv/blmsa_pkg.sv @@
// Shared widths and types for the bounded-length maximum subarray unit.
`default_nettype none

package blmsa_pkg;

    localparam int VALUE_W = 40;
    localparam int SUM_W   = 51;
    localparam int IDX_W   = 11;
    localparam int LEN_W   = 9;

    typedef struct packed {
        logic step;
        logic seed;
        logic emit;
    } best_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] last_idx;
    } cand_t;

endpackage

`default_nettype wire

@@ sv/blmsa_best.sv @@
// Best-run tracker and result register of the bounded-length maximum subarray unit.
`default_nettype none

module blmsa_best (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire blmsa_pkg::best_ctl_t        ctl,
    input  wire blmsa_pkg::cand_t            cand,
    output logic                             can_emit,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [blmsa_pkg::SUM_W-1:0]      best_total,
    output logic [blmsa_pkg::IDX_W-1:0]      start_index,
    output logic [blmsa_pkg::IDX_W-1:0]      end_index
);

    localparam int SUM_W = blmsa_pkg::SUM_W;
    localparam int IDX_W = blmsa_pkg::IDX_W;

    logic [SUM_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic [IDX_W-1:0] final_reg, final_next;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_total_reg, out_total_next;
    logic [IDX_W-1:0] out_start_reg, out_start_next;
    logic [IDX_W-1:0] out_end_reg, out_end_next;
    logic             take;

    assign take = ctl.step && (ctl.seed || ($signed(cand.total) > $signed(best_reg)));

    always_comb
    begin
        best_next      = best_reg;
        first_next     = first_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        out_total_next = out_total_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        if (take)
        begin
            best_next  = cand.total;
            first_next = cand.first_idx;
            final_next = cand.last_idx;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.step && ctl.emit)
        begin
            out_valid_next = 1'b1;
            out_total_next = best_next;
            out_start_next = first_next;
            out_end_next   = final_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= '0;
            first_reg     <= IDX_W'(1);
            final_reg     <= IDX_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            best_reg      <= best_next;
            first_reg     <= first_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_total_reg <= out_total_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
    end

    assign can_emit    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign best_total  = out_total_reg;
    assign start_index = out_start_reg;
    assign end_index   = out_end_reg;

endmodule

`default_nettype wire

@@ sv/bounded_length_max_subarray_unit.sv @@
// Top level of the bounded-length maximum subarray unit: deque memory and sequencer.
`default_nettype none

// Each accepted word passes through the states S_BACK (only when the deque holds
// entries), S_PUSH, S_FRONT and S_UPDATE; S_BACK and S_FRONT walk the deque one
// entry per cycle and drop entries from the back and the front, each entry at most
// once. The deque memory has one registered read port. A new word is taken while a
// finished result still waits in the output register; the sequencer stalls only if
// a second result would overwrite it. There is no clearing pass after reset. Changes
// to max_length are not deferred: a write while a word is in work applies to it.

module bounded_length_max_subarray_unit #(
    parameter int MAX_ITEMS  = 1024,
    parameter int MAX_WINDOW = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            max_length_we,
    input  wire logic [blmsa_pkg::LEN_W-1:0]     max_length,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [blmsa_pkg::VALUE_W-1:0]   value,
    input  wire logic                            last,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [blmsa_pkg::SUM_W-1:0]          best_total,
    output logic [blmsa_pkg::IDX_W-1:0]          start_index,
    output logic [blmsa_pkg::IDX_W-1:0]          end_index
);

    localparam int VALUE_W = blmsa_pkg::VALUE_W;
    localparam int SUM_W   = blmsa_pkg::SUM_W;
    localparam int IDX_W   = blmsa_pkg::IDX_W;
    localparam int LEN_W   = blmsa_pkg::LEN_W;
    localparam int DQ      = MAX_WINDOW + 1;
    localparam int AW      = $clog2(DQ);
    localparam int FW      = $clog2(DQ + 1);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int WW      = $clog2(MAX_WINDOW + 1);
    localparam int LW      = (WW > LEN_W) ? WW : LEN_W;
    localparam int CMP_W   = ((CNT_W > LW) ? CNT_W : LW) + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BACK   = 3'd1;
    localparam logic [2:0] S_PUSH   = 3'd2;
    localparam logic [2:0] S_FRONT  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;

    function automatic logic [AW-1:0] dq_dec(input logic [AW-1:0] a);
        dq_dec = (a == AW'(0)) ? AW'(DQ - 1) : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] dq_inc(input logic [AW-1:0] a);
        dq_inc = (a == AW'(DQ - 1)) ? AW'(0) : a + AW'(1);
    endfunction

    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] max_length_reg;
    logic [SUM_W-1:0] prefix_reg, prefix_next;
    logic [SUM_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             last_reg, last_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             fwd_reg, fwd_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W-1:0] first_reg, first_next;

    logic [SUM_W-1:0] mem_prefix [DQ];
    logic [CNT_W-1:0] mem_pos [DQ];
    logic [SUM_W-1:0] rd_prefix_reg;
    logic [CNT_W-1:0] rd_pos_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;

    logic             fresh;
    logic [SUM_W-1:0] acc_base;
    logic [SUM_W-1:0] value_ext;
    logic [CNT_W-1:0] acc_pos;
    logic             acc_last;
    logic [LEN_W-1:0] len_nz;
    logic [LW-1:0]    len_ext;
    logic [LW-1:0]    win;
    logic [SUM_W-1:0] front_prefix;
    logic [CNT_W-1:0] front_pos;
    logic             drop_front;

    blmsa_pkg::best_ctl_t ctl;
    blmsa_pkg::cand_t     cand;
    logic                 can_emit;

    assign fresh     = (count_reg == '0);
    assign acc_base  = fresh ? '0 : prefix_reg;
    assign value_ext = {{(SUM_W - VALUE_W){value[VALUE_W-1]}}, value};
    assign acc_pos   = count_reg + CNT_W'(1);
    assign acc_last  = last || (acc_pos == CNT_W'(MAX_ITEMS));

    assign len_nz  = (max_length_reg == '0) ? LEN_W'(1) : max_length_reg;
    assign len_ext = LW'(len_nz);
    assign win     = (len_ext > LW'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : len_ext;

    assign front_prefix = fwd_reg ? prev_reg : rd_prefix_reg;
    assign front_pos    = fwd_reg ? (pos_reg - CNT_W'(1)) : rd_pos_reg;
    assign drop_front   = CMP_W'(pos_reg) > (CMP_W'(front_pos) + CMP_W'(win));

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        prefix_next = prefix_reg;
        prev_next   = prev_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        fwd_next    = fwd_reg;
        sum_next    = sum_reg;
        first_next  = first_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        mem_we      = 1'b0;
        ctl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    prev_next   = acc_base;
                    prefix_next = acc_base + value_ext;
                    pos_next    = acc_pos;
                    last_next   = acc_last;
                    count_next  = acc_last ? '0 : acc_pos;
                    if (fresh)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        fill_next  = '0;
                        state_next = S_PUSH;
                    end
                    else if (fill_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = dq_dec(tail_reg);
                        state_next = S_BACK;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_BACK:
            begin
                if ($signed(prev_reg) <= $signed(rd_prefix_reg))
                begin
                    tail_next = dq_dec(tail_reg);
                    fill_next = fill_reg - FW'(1);
                    if (fill_reg != FW'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = dq_dec(dq_dec(tail_reg));
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                mem_we     = 1'b1;
                tail_next  = dq_inc(tail_reg);
                fill_next  = fill_reg + FW'(1);
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                fwd_next   = (head_reg == tail_reg);
                state_next = S_FRONT;
            end
            S_FRONT:
            begin
                if (drop_front)
                begin
                    head_next = dq_inc(head_reg);
                    fill_next = fill_reg - FW'(1);
                    rd_en     = 1'b1;
                    rd_addr   = dq_inc(head_reg);
                    fwd_next  = 1'b0;
                end
                else
                begin
                    sum_next   = prefix_reg - front_prefix;
                    first_next = IDX_W'(front_pos + CNT_W'(1));
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (!last_reg || can_emit)
                begin
                    ctl.step   = 1'b1;
                    ctl.emit   = last_reg;
                    ctl.seed   = (pos_reg == CNT_W'(1));
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_length_reg <= LEN_W'(1);
            prefix_reg     <= '0;
            count_reg      <= '0;
            last_reg       <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            fwd_reg    <= fwd_next;
            if (max_length_we)
            begin
                max_length_reg <= max_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        pos_reg   <= pos_next;
        sum_reg   <= sum_next;
        first_reg <= first_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_prefix[tail_reg] <= prev_reg;
            mem_pos[tail_reg]    <= pos_reg - CNT_W'(1);
        end
        if (rd_en)
        begin
            rd_prefix_reg <= mem_prefix[rd_addr];
            rd_pos_reg    <= mem_pos[rd_addr];
        end
    end

    assign cand.total     = sum_reg;
    assign cand.first_idx = first_reg;
    assign cand.last_idx  = IDX_W'(pos_reg);

    blmsa_best u_best (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cand        (cand),
        .can_emit    (can_emit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .best_total  (best_total),
        .start_index (start_index),
        .end_index   (end_index)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DQ))
        else $error("deque fill count exceeds its capacity");

    a_front_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRONT) |-> (fill_reg != '0))
        else $error("deque front examined while the deque is empty");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && last_reg && can_emit) |=> out_valid)
        else $error("final word of a sequence produced no result");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while the first is still in work");

endmodule

`default_nettype wire

@@ verif/bounded_length_max_subarray_unit_test.sv @@
// Self-checking testbench for the bounded-length maximum subarray unit.
`timescale 1ns / 1ps

module bounded_length_max_subarray_unit_test;

    localparam int VALUE_W = blmsa_pkg::VALUE_W;
    localparam int SUM_W   = blmsa_pkg::SUM_W;
    localparam int IDX_W   = blmsa_pkg::IDX_W;
    localparam int LEN_W   = blmsa_pkg::LEN_W;

    localparam int MAX_ITEMS_P  = 1024;
    localparam int MAX_WIN      = 256;
    localparam int RING         = MAX_WIN + 1;
    localparam int SETTLE       = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 520;
    localparam longint VAL_TOP  = (longint'(1) <<< 39) - 1;
    localparam longint VAL_BOT  = -(longint'(1) <<< 39);

    typedef enum int {
        FULL_RANGE,
        NEAR_ZERO,
        RAILS,
        MIXED_STYLE
    } value_style_t;

    typedef struct {
        bit     cfg_we;
        int     cfg_val;
        longint val;
        bit     lst;
        bit     typed;
        longint want_total;
        int     want_first;
        int     want_last;
    } word_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 max_length_we = 1'b0;
    logic [LEN_W-1:0]     max_length = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [VALUE_W-1:0]   value = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [SUM_W-1:0]     best_total;
    logic [IDX_W-1:0]     start_index;
    logic [IDX_W-1:0]     end_index;

    blmsa_pkg::cand_t best_runs_due[$];
    word_row_t  word_table[$];
    int         errors = 0;
    int         words_sent = 0;
    int         results_seen = 0;
    int         window_writes = 0;
    bit         source_calm = 1'b0;

    // Running state of the expected behavior.
    logic [LEN_W-1:0] length_limit = 1;
    longint           prefix_acc = 0;
    int               run_count = 0;
    longint           ring_prefix[RING];
    int               ring_pos[RING];
    int               ring_head = 0;
    int               ring_tail = 0;
    int               ring_fill = 0;
    longint           top_sum = 0;
    int               top_first = 1;
    int               top_end = 1;

    bounded_length_max_subarray_unit #(
        .MAX_ITEMS  (MAX_ITEMS_P),
        .MAX_WINDOW (MAX_WIN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_length_we (max_length_we),
        .max_length    (max_length),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .best_total    (best_total),
        .start_index   (start_index),
        .end_index     (end_index)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic bit advance_best_run(input logic [VALUE_W-1:0] v, input bit l,
                                            output blmsa_pkg::cand_t run);
        longint sample;
        longint prev;
        longint sum;
        int     span;
        int     pos;
        int     back;
        bit     popping;
        sample = longint'($signed(v));
        span = (length_limit == 0) ? 1 :
               ((length_limit > MAX_WIN) ? MAX_WIN : int'(length_limit));
        if (run_count == 0)
        begin
            prefix_acc = 0;
            ring_head = 0;
            ring_tail = 0;
            ring_fill = 0;
        end
        prev = prefix_acc;
        pos = run_count + 1;
        prefix_acc += sample;
        popping = 1'b1;
        while (popping && ring_fill > 0)
        begin
            back = (ring_tail + RING - 1) % RING;
            if (prev > ring_prefix[back])
                popping = 1'b0;
            else
            begin
                ring_tail = back;
                ring_fill--;
            end
        end
        ring_prefix[ring_tail] = prev;
        ring_pos[ring_tail] = pos - 1;
        ring_tail = (ring_tail + 1) % RING;
        ring_fill++;
        while (ring_fill > 0 && pos > ring_pos[ring_head] + span)
        begin
            ring_head = (ring_head + 1) % RING;
            ring_fill--;
        end
        sum = prefix_acc - ring_prefix[ring_head];
        if (pos == 1 || sum > top_sum)
        begin
            top_sum = sum;
            top_first = ring_pos[ring_head] + 1;
            top_end = pos;
        end
        run_count = pos;
        run = '0;
        if (l || pos >= MAX_ITEMS_P)
        begin
            run.total = top_sum[SUM_W-1:0];
            run.first_idx = IDX_W'(top_first);
            run.last_idx = IDX_W'(top_end);
            run_count = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] next_value(input value_style_t style);
        value_style_t s;
        logic [63:0]  raw;
        s = style;
        if (s == MIXED_STYLE)
            s = value_style_t'($urandom_range(0, 2));
        raw = {$urandom, $urandom};
        case (s)
            NEAR_ZERO: return VALUE_W'(longint'($urandom_range(0, 12)) - 6);
            RAILS:     return $urandom_range(0, 1) ? VALUE_W'(VAL_TOP) : VALUE_W'(VAL_BOT);
            default:   return raw[VALUE_W-1:0];
        endcase
    endfunction

    function automatic void add_row(input bit we, input int c, input longint v, input bit l,
                                    input bit typed, input longint wt, input int wf,
                                    input int wl);
        word_row_t row;
        row.cfg_we = we;
        row.cfg_val = c;
        row.val = v;
        row.lst = l;
        row.typed = typed;
        row.want_total = wt;
        row.want_first = wf;
        row.want_last = wl;
        word_table.push_back(row);
    endfunction

    // The caller is at a clock edge; valid stays high after the handshake.
    task automatic send_word(input logic [VALUE_W-1:0] v, input bit l, input bit typed,
                             input blmsa_pkg::cand_t typed_run);
        int               gap;
        blmsa_pkg::cand_t run;
        gap = pick_gap(source_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        last <= l;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        words_sent++;
        if (advance_best_run(v, l, run))
            best_runs_due.push_back(typed ? typed_run : run);
    endtask

    task automatic set_window(input int w);
        in_valid <= 1'b0;
        while (best_runs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        max_length_we <= 1'b1;
        max_length <= LEN_W'(w);
        @(posedge clk);
        max_length_we <= 1'b0;
        length_limit = LEN_W'(w);
        window_writes++;
    endtask

    initial
    begin : result_sink
        blmsa_pkg::cand_t want;
        int               hold_left;
        bit               sink_calm;
        hold_left = 0;
        sink_calm = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready)
            begin
                results_seen++;
                if (best_runs_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, total %0d start %0d end %0d", $time,
                             $signed(best_total), start_index, end_index);
                end
                else
                begin
                    want = best_runs_due.pop_front();
                    if (best_total !== want.total)
                    begin
                        errors++;
                        $display("%0t: best_total expected %0d got %0d", $time,
                                 $signed(want.total), $signed(best_total));
                    end
                    if (start_index !== want.first_idx)
                    begin
                        errors++;
                        $display("%0t: start_index expected %0d got %0d", $time,
                                 want.first_idx, start_index);
                    end
                    if (end_index !== want.last_idx)
                    begin
                        errors++;
                        $display("%0t: end_index expected %0d got %0d", $time,
                                 want.last_idx, end_index);
                    end
                end
            end
            if ($urandom_range(0, 149) == 0)
                sink_calm = !sink_calm;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    hold_left = pick_gap(sink_calm);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int               len;
        int               w;
        int               random_words;
        int               seq_count;
        value_style_t     style;
        blmsa_pkg::cand_t want;

        add_row(0, 0, VAL_TOP, 1, 1, VAL_TOP, 1, 1);
        add_row(0, 0, VAL_BOT, 1, 1, VAL_BOT, 1, 1);
        add_row(0, 0, 5, 0, 0, 0, 0, 0);
        add_row(0, 0, 7, 1, 1, 7, 2, 2);
        add_row(1, 0, 3, 0, 0, 0, 0, 0);
        add_row(0, 0, 3, 1, 1, 3, 1, 1);
        add_row(1, 511, -1, 0, 0, 0, 0, 0);
        add_row(0, 0, 4, 0, 0, 0, 0, 0);
        add_row(0, 0, -2, 0, 0, 0, 0, 0);
        add_row(0, 0, 5, 1, 1, 7, 2, 4);
        add_row(1, 2, 4, 0, 0, 0, 0, 0);
        add_row(0, 0, -1, 0, 0, 0, 0, 0);
        add_row(0, 0, 4, 1, 1, 4, 1, 1);
        add_row(1, 1, 2, 0, 0, 0, 0, 0);
        add_row(1, 3, -1, 0, 0, 0, 0, 0);
        add_row(0, 0, 6, 1, 0, 0, 0, 0);
        add_row(1, 256, VAL_TOP, 0, 0, 0, 0, 0);
        add_row(0, 0, VAL_TOP, 0, 0, 0, 0, 0);
        add_row(0, 0, VAL_TOP, 1, 0, 0, 0, 0);
        add_row(0, 0, VAL_BOT, 0, 0, 0, 0, 0);
        add_row(0, 0, VAL_BOT, 1, 0, 0, 0, 0);
        add_row(1, 257, -3, 0, 0, 0, 0, 0);
        add_row(0, 0, 2, 0, 0, 0, 0, 0);
        add_row(0, 0, -1, 1, 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (word_table[i])
        begin
            if (word_table[i].cfg_we)
                set_window(word_table[i].cfg_val);
            want.total = SUM_W'(word_table[i].want_total);
            want.first_idx = IDX_W'(word_table[i].want_first);
            want.last_idx = IDX_W'(word_table[i].want_last);
            send_word(VALUE_W'(word_table[i].val), word_table[i].lst,
                      word_table[i].typed, want);
        end

        random_words = 0;
        seq_count = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (seq_count % 6 == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       w = 0;
                    1:       w = 1;
                    2:       w = $urandom_range(2, 4);
                    3, 4:    w = $urandom_range(2, 32);
                    5:       w = $urandom_range(33, 255);
                    6:       w = 256;
                    default: w = $urandom_range(257, 511);
                endcase
                set_window(w);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 20);
                7, 8:                len = $urandom_range(21, 120);
                default:             len = $urandom_range(121, 400);
            endcase
            style = value_style_t'($urandom_range(0, 3));
            source_calm = ($urandom_range(0, 3) == 0);
            for (int k = 1; k <= len; k++)
                send_word(next_value(style), k == len, 1'b0, '0);
            random_words += len;
            seq_count++;
        end

        // A sequence that never raises last is closed by the item limit.
        set_window($urandom_range(1, 300));
        source_calm = 1'b0;
        for (int k = 1; k <= MAX_ITEMS_P; k++)
            send_word(next_value(MIXED_STYLE), 1'b0, 1'b0, '0);
        for (int k = 1; k <= 3; k++)
            send_word(next_value(MIXED_STYLE), k == 3, 1'b0, '0);

        in_valid <= 1'b0;
        while (best_runs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d words over %0d length settings and checked %0d results,",
                 words_sent, window_writes, results_seen);
        $display("including one sequence closed by the %0d-item limit.", MAX_ITEMS_P);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
